@@ rtl/vsa_pkg.sv @@
package vsa_pkg;

    localparam int IDX_W   = 12;
    localparam int DOM_W   = 27;
    localparam int SUSP_W  = 16;
    localparam int COUNT_W = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam int ORDER_W = 3;
    localparam int VALUE_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MODE = CFG_IDX_W'(1);

    // order modes; unlisted codes behave as ORDER_FIRST
    localparam logic [ORDER_W-1:0] ORDER_FIRST    = 3'd0;
    localparam logic [ORDER_W-1:0] ORDER_MIN_SIZE = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_MAX_MAX  = 3'd2;
    localparam logic [ORDER_W-1:0] ORDER_MIN_MIN  = 3'd3;
    localparam logic [ORDER_W-1:0] ORDER_MAX_SUSP = 3'd4;

    // value modes; the unlisted code behaves as VALUE_MID
    localparam logic [VALUE_W-1:0] VALUE_MIN = 2'd0;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 2'd1;
    localparam logic [VALUE_W-1:0] VALUE_MID = 2'd2;

    localparam logic STATUS_CHOSEN = 1'b0;
    localparam logic STATUS_EMPTY  = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]  var_index;
        logic              is_determined;
        logic [DOM_W-1:0]  dom_size;
        logic [DOM_W-1:0]  dom_min;
        logic [DOM_W-1:0]  dom_max;
        logic [DOM_W-1:0]  dom_mid;
        logic [SUSP_W-1:0] susp_count;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [IDX_W-1:0]   selected_index;
        logic [DOM_W-1:0]   chosen_value;
        logic [COUNT_W-1:0] kept_count;
    } out_item_t;

    // keys that take part in the ordering
    typedef struct packed {
        logic [DOM_W-1:0]  size;
        logic [DOM_W-1:0]  min;
        logic [DOM_W-1:0]  max;
        logic [SUSP_W-1:0] susps;
    } order_key_t;

endpackage

@@ rtl/vsa_cmp.sv @@
module vsa_cmp (
    input  logic [vsa_pkg::ORDER_W-1:0] order_mode,
    input  vsa_pkg::order_key_t         cand,
    input  vsa_pkg::order_key_t         best,
    output logic                        beats
);
    import vsa_pkg::*;

    always_comb begin
        unique case (order_mode)
            ORDER_MIN_SIZE: beats = cand.size < best.size;
            ORDER_MAX_MAX:  beats = cand.max > best.max;
            ORDER_MIN_MIN:  beats = cand.min < best.min;
            ORDER_MAX_SUSP: begin
                if (cand.susps != best.susps) begin
                    beats = cand.susps > best.susps;
                end else begin
                    beats = cand.size < best.size;
                end
            end
            default: beats = 1'b0;
        endcase
    end

endmodule

@@ rtl/variable_selection_argbest.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------
// input    | s_valid / s_ready  | s_data   (vsa_pkg::in_item_t)
// result   | m_valid / m_ready  | m_data   (vsa_pkg::out_item_t)
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One descriptor per cycle, bar a last item held by a stalled result: each
// transaction is registered, then compared against the registered best (a
// 27-bit compare, or a 16-bit compare and a 27-bit compare in suspension
// order). The result is then registered. Reset clears the handshake state,
// the scan state and both mode registers. A stalled result holds only
// items marked last; other items keep flowing while the result waits.
module variable_selection_argbest #(
    parameter int MAX_ITEMS = 4096
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  vsa_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output vsa_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vsa_pkg::*;

    localparam int CountCapInt = (MAX_ITEMS < 8191) ? MAX_ITEMS : 8191;
    localparam logic [COUNT_W-1:0] CountCap = COUNT_W'(CountCapInt);

    logic [ORDER_W-1:0] order_mode_reg;
    logic [VALUE_W-1:0] value_mode_reg;

    logic               in_valid_reg;
    in_item_t           in_item_reg;

    logic               have_best_reg, have_best_next;
    logic [IDX_W-1:0]   best_index_reg, best_index_next;
    order_key_t         best_key_reg, best_key_next;
    logic [DOM_W-1:0]   best_mid_reg, best_mid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               out_valid_reg;
    out_item_t          out_item_reg, out_item_next;

    order_key_t         cand_key;
    logic               beats;
    logic               advance;
    logic               take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_mode_reg <= ORDER_FIRST;
            value_mode_reg <= VALUE_MIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ORDER_MODE: order_mode_reg <= cfg_data[ORDER_W-1:0];
                REG_VALUE_MODE: value_mode_reg <= cfg_data[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // a last item needs a free result register to move on
    assign advance = in_valid_reg &&
                     (!in_item_reg.last || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    assign cand_key = '{size:  in_item_reg.dom_size,
                        min:   in_item_reg.dom_min,
                        max:   in_item_reg.dom_max,
                        susps: in_item_reg.susp_count};

    vsa_cmp u_cmp (
        .order_mode (order_mode_reg),
        .cand       (cand_key),
        .best       (best_key_reg),
        .beats      (beats)
    );

    assign take = !in_item_reg.is_determined && (!have_best_reg || beats);

    always_comb begin
        have_best_next  = have_best_reg;
        best_index_next = best_index_reg;
        best_key_next   = best_key_reg;
        best_mid_next   = best_mid_reg;
        count_next      = count_reg;
        if (!in_item_reg.is_determined && count_reg < CountCap) begin
            count_next = count_reg + COUNT_W'(1);
        end
        if (take) begin
            have_best_next  = 1'b1;
            best_index_next = in_item_reg.var_index;
            best_key_next   = cand_key;
            best_mid_next   = in_item_reg.dom_mid;
        end
    end

    always_comb begin
        out_item_next = '0;
        if (have_best_next) begin
            out_item_next.status         = STATUS_CHOSEN;
            out_item_next.selected_index = best_index_next;
            out_item_next.kept_count     = count_next;
            unique case (value_mode_reg)
                VALUE_MIN: out_item_next.chosen_value = best_key_next.min;
                VALUE_MAX: out_item_next.chosen_value = best_key_next.max;
                default:   out_item_next.chosen_value = best_mid_next;
            endcase
        end else begin
            out_item_next.status = STATUS_EMPTY;
        end
    end

    // clear the scan after the last item of a vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_best_reg  <= 1'b0;
            best_index_reg <= '0;
            best_key_reg   <= '0;
            best_mid_reg   <= '0;
            count_reg      <= '0;
        end else if (advance) begin
            if (in_item_reg.last) begin
                have_best_reg  <= 1'b0;
                best_index_reg <= '0;
                best_key_reg   <= '0;
                best_mid_reg   <= '0;
                count_reg      <= '0;
            end else begin
                have_best_reg  <= have_best_next;
                best_index_reg <= best_index_next;
                best_key_reg   <= best_key_next;
                best_mid_reg   <= best_mid_next;
                count_reg      <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last) begin
            out_item_reg <= out_item_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

@@ dv/tb_variable_selection_argbest.sv @@
`timescale 1ns / 1ps

module tb_variable_selection_argbest;
    import vsa_pkg::*;

    localparam int MAX_ITEMS       = 4096;
    localparam int KEPT_CAP        = (MAX_ITEMS < 8191) ? MAX_ITEMS : 8191;
    localparam int NUM_PHASES      = 18;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 24;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    variable_selection_argbest #(
        .MAX_ITEMS(MAX_ITEMS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mode registers as the block should hold them
    logic [ORDER_W-1:0] order_sel = ORDER_FIRST;
    logic [VALUE_W-1:0] value_sel = VALUE_MIN;

    // running best of the vector under scan
    logic               scan_found = 1'b0;
    logic [IDX_W-1:0]   scan_index = '0;
    order_key_t         scan_key   = '0;
    logic [DOM_W-1:0]   scan_mid   = '0;
    logic [COUNT_W-1:0] scan_kept  = '0;

    in_item_t    descriptor_queue[$];
    out_item_t   expected_results[$];
    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned fail_count     = 0;
    int unsigned stall_cycles   = 0;
    int unsigned send_gap       = 0;
    int unsigned hold_cycles    = 0;
    logic        tx_calm        = 1'b0;
    logic        rx_calm        = 1'b0;

    function automatic int unsigned draw_gap(input logic calm);
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic outranks(input in_item_t d);
        case (order_sel)
            ORDER_MIN_SIZE: return d.dom_size < scan_key.size;
            ORDER_MAX_MAX:  return d.dom_max > scan_key.max;
            ORDER_MIN_MIN:  return d.dom_min < scan_key.min;
            ORDER_MAX_SUSP: begin
                if (d.susp_count != scan_key.susps)
                    return d.susp_count > scan_key.susps;
                return d.dom_size < scan_key.size;
            end
            default:        return 1'b0;
        endcase
    endfunction

    // fold one descriptor into the scan; a last descriptor closes the vector
    function automatic void fold_descriptor(input in_item_t d);
        out_item_t r;
        if (!d.is_determined) begin
            if (scan_kept < KEPT_CAP)
                scan_kept++;
            if (!scan_found || outranks(d)) begin
                scan_found      = 1'b1;
                scan_index      = d.var_index;
                scan_key.size   = d.dom_size;
                scan_key.min    = d.dom_min;
                scan_key.max    = d.dom_max;
                scan_key.susps  = d.susp_count;
                scan_mid        = d.dom_mid;
            end
        end
        if (d.last) begin
            r = '0;
            if (scan_found) begin
                r.status         = STATUS_CHOSEN;
                r.selected_index = scan_index;
                r.kept_count     = scan_kept;
                case (value_sel)
                    VALUE_MIN: r.chosen_value = scan_key.min;
                    VALUE_MAX: r.chosen_value = scan_key.max;
                    default:   r.chosen_value = scan_mid;
                endcase
            end else begin
                r.status = STATUS_EMPTY;
            end
            expected_results.push_back(r);
            scan_found = 1'b0;
            scan_index = '0;
            scan_key   = '0;
            scan_mid   = '0;
            scan_kept  = '0;
        end
    endfunction

    function automatic void check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("unexpected result: status %0d index %0d value %0d kept %0d",
                         got.status, got.selected_index, got.chosen_value, got.kept_count);
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status || got.selected_index !== want.selected_index ||
            got.chosen_value !== want.chosen_value || got.kept_count !== want.kept_count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $write("result mismatch: expected status %0d index %0d value %0d kept %0d,",
                       want.status, want.selected_index, want.chosen_value, want.kept_count);
                $display(" got status %0d index %0d value %0d kept %0d",
                         got.status, got.selected_index, got.chosen_value, got.kept_count);
            end
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                fold_descriptor(s_data);
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (descriptor_queue.size() != 0) begin
                    s_data   <= descriptor_queue.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= draw_gap(tx_calm);
                end else begin
                    s_valid  <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        int unsigned g;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_cycles <= 0;
        end else if (m_valid && m_ready) begin
            check_result(m_data);
            g = draw_gap(rx_calm);
            hold_cycles <= g;
            m_ready     <= (g == 0);
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready     <= (hold_cycles == 1);
        end else begin
            m_ready     <= 1'b1;
        end
    end

    // watchdog: end the run if no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("variable_selection_argbest regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic in_item_t mk(input logic [IDX_W-1:0] idx, input logic det,
                                    input logic [DOM_W-1:0] sz, input logic [DOM_W-1:0] mn,
                                    input logic [DOM_W-1:0] mx, input logic [DOM_W-1:0] md,
                                    input logic [SUSP_W-1:0] su, input logic last);
        in_item_t d;
        d.var_index     = idx;
        d.is_determined = det;
        d.dom_size      = sz;
        d.dom_min       = mn;
        d.dom_max       = mx;
        d.dom_mid       = md;
        d.susp_count    = su;
        d.last          = last;
        return d;
    endfunction

    function automatic void queue_item(input in_item_t d);
        descriptor_queue.push_back(d);
        queued_total++;
    endfunction

    // small pools make ties common, the full range reaches every bit
    function automatic logic [DOM_W-1:0] draw_dom();
        case ($urandom_range(0, 3))
            0:       return DOM_W'($urandom_range(0, 3));
            1:       return {DOM_W{1'b1}} - DOM_W'($urandom_range(0, 3));
            2:       return DOM_W'($urandom_range(0, 300));
            default: return DOM_W'($urandom);
        endcase
    endfunction

    function automatic logic [SUSP_W-1:0] draw_susp();
        case ($urandom_range(0, 3))
            0:       return SUSP_W'($urandom_range(0, 3));
            1:       return {SUSP_W{1'b1}} - SUSP_W'($urandom_range(0, 3));
            2:       return SUSP_W'($urandom_range(0, 50));
            default: return SUSP_W'($urandom);
        endcase
    endfunction

    function automatic void queue_vector(input int len, input int det_pct);
        in_item_t d;
        for (int i = 0; i < len; i++) begin
            d.var_index     = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'(i);
            d.is_determined = ($urandom_range(0, 99) < det_pct);
            d.dom_size      = draw_dom();
            d.dom_min       = draw_dom();
            d.dom_max       = draw_dom();
            d.dom_mid       = draw_dom();
            d.susp_count    = draw_susp();
            d.last          = (i == len - 1);
            queue_item(d);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            REG_ORDER_MODE: order_sel = val[ORDER_W-1:0];
            REG_VALUE_MODE: value_sel = val[VALUE_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained(input int settle);
        @(posedge aclk);
        while (accepted_total != queued_total || expected_results.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    initial begin
        logic [ORDER_W-1:0]    order_pick;
        logic [VALUE_W-1:0]    value_pick;
        logic [CFG_DATA_W-1:0] word;
        int                    phase_items;
        int                    len;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed vectors under the reset modes (first wins, domain minimum)
        // empty vector: one bound variable
        queue_item(mk('1, 1'b1, '1, '1, '1, '1, '1, 1'b1));
        // lone variable at the top of every field
        queue_item(mk('1, 1'b0, '1, '1, '1, '1, '1, 1'b1));
        // lone variable at zero, size below the legal floor
        queue_item(mk('0, 1'b0, '0, '0, '0, '0, '0, 1'b1));
        // bound variables only
        queue_item(mk(12'd7, 1'b1, 27'd2, 27'd0, 27'd1, 27'd0, 16'd9, 1'b0));
        queue_item(mk(12'd8, 1'b1, 27'd1, 27'd3, 27'd3, 27'd3, 16'd0, 1'b0));
        queue_item(mk(12'd9, 1'b1, 27'd5, 27'd1, 27'd5, 27'd3, 16'd2, 1'b1));
        // bound variables never win; equal keys keep the earlier one
        queue_item(mk(12'd1, 1'b1, 27'd1, 27'd0, '1, 27'd5, '1, 1'b0));
        queue_item(mk(12'd2, 1'b0, 27'd9, 27'd4, 27'd7, 27'd5, 16'd3, 1'b0));
        queue_item(mk(12'd3, 1'b0, 27'd9, 27'd4, 27'd7, 27'd6, 16'd3, 1'b0));
        queue_item(mk(12'd4, 1'b0, 27'd2, 27'd1, 27'd3, 27'd2, 16'd3, 1'b0));
        queue_item(mk(12'd5, 1'b1, 27'd1, 27'd0, '1, 27'd0, '1, 1'b1));
        // first variable keeps the lead; the last item does not replace it
        queue_item(mk(12'd6, 1'b0, 27'd40, 27'd30, 27'd50, 27'd40, 16'd1, 1'b0));
        queue_item(mk(12'd10, 1'b0, 27'd3, 27'd2, 27'd90, 27'd4, 16'd8, 1'b1));
        wait_drained(SETTLE_CYCLES);

        for (int p = 1; p < NUM_PHASES; p++) begin
            if (p <= 8) begin
                order_pick = ORDER_W'(p - 1);
                value_pick = VALUE_W'(p - 1);
            end else begin
                order_pick = ORDER_W'($urandom_range(0, 7));
                value_pick = VALUE_W'($urandom_range(0, 3));
            end
            // upper data bits are don't-care; drive them anyway
            word = CFG_DATA_W'($urandom);
            word[ORDER_W-1:0] = order_pick;
            write_reg(REG_ORDER_MODE, word);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
            word = CFG_DATA_W'($urandom);
            word[VALUE_W-1:0] = value_pick;
            write_reg(REG_VALUE_MODE, word);

            tx_calm <= ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                len = $urandom_range(1, 12);
                queue_vector(len, ($urandom_range(0, 9) == 0) ? 100 : 25);
                phase_items += len;
            end
            wait_drained((p == NUM_PHASES - 1) ? DRAIN_CYCLES : SETTLE_CYCLES);
        end

        if (fail_count == 0)
            $display("variable_selection_argbest regression: pass");
        else
            $display("variable_selection_argbest regression: fail");
        $finish;
    end

endmodule
